// ----- rtl/flki_pkg.sv -----
// ----------------------------------------------------------------------------
// flki_pkg
// constants, cordic tables and rounding helpers for the kinematics integrator
// ----------------------------------------------------------------------------
package flki_pkg;

    localparam int ANGLE_WIDTH       = 32;
    localparam int LATLON_WIDTH      = 48;
    localparam int CORDIC_ITERATIONS = 24;
    localparam int EARTH_RADIUS_M    = 6400000;
    localparam int SPEED_WIDTH       = 24;
    localparam int ALT_WIDTH         = 32;
    localparam int GAIN_WIDTH        = 16;
    localparam int ANG_FRAC          = ANGLE_WIDTH - 4;
    localparam int LL_FRAC           = LATLON_WIDTH - 4;
    localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    localparam logic REG_LAG_GAIN  = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    typedef logic [61:0] atan_tbl_t [CORDIC_ITERATIONS];

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] udiv_scaled(input logic [63:0] n, input logic [63:0] d,
                                                input int k);
        logic [63:0] q;
        logic [63:0] r;
        q = udiv64(n, d);
        r = n - q * d;
        for (int i = 0; i < 64; i++) begin
            if (i < k) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 64'd1;
                end
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bv;
        logic [63:0] nn;
        res = '0;
        bv  = 64'd1 << 62;
        nn  = n;
        for (int j = 0; j < 32; j++) begin
            if (bv > nn) begin
                bv = bv >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bv != 0) begin
                if (nn >= res + bv) begin
                    nn  = nn - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
        end
        return res;
    endfunction

    function automatic atan_tbl_t build_atan();
        atan_tbl_t   tbl;
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        tbl[0] = 62'((((PI_Q62 >> 2) + 64'd8) >> 4));
        for (int i = 1; i < CORDIC_ITERATIONS; i++) begin
            sum = '0;
            for (int k = 0; k < 64; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = udiv64(64'd1 << e, 64'(2 * k + 1));
                    if ((k & 1) != 0) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            tbl[i] = 62'((sum + 64'd8) >> 4);
        end
        return tbl;
    endfunction

    function automatic logic [63:0] build_gain();
        logic [63:0] p;
        logic [63:0] sq;
        p = 64'd1 << 30;
        for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            if (2 * i < 63) begin
                p = p + (p >> (2 * i));
            end
        end
        sq = isqrt64(p << 30);
        return udiv64((64'd1 << 60) + (sq >> 1), sq);
    endfunction

    function automatic logic [63:0] deg_to_ll(input logic [63:0] ten_thousandths);
        logic [63:0] q;
        q = udiv_scaled((PI_Q62 >> 22) * ten_thousandths, 64'd1800000, 20);
        return (q + (64'd1 << (60 - LL_FRAC - 1))) >> (60 - LL_FRAC);
    endfunction

    localparam atan_tbl_t ATAN_TBL = build_atan();
    localparam logic [63:0] GAIN_Q30 = build_gain();

    localparam logic signed [63:0] PI_Q58     = $signed((PI_Q62 + 64'd8) >> 4);
    localparam logic signed [63:0] HALF_PI_Q58 = PI_Q58 >>> 1;
    localparam logic signed [63:0] TWO_PI_Q58 = PI_Q58 <<< 1;
    localparam logic signed [33:0] PI_ANG =
        34'(($signed((PI_Q62 + (64'd1 << (61 - ANG_FRAC))) >> (62 - ANG_FRAC))));
    localparam logic signed [33:0] TWO_PI_ANG = PI_ANG <<< 1;

    localparam logic signed [ANGLE_WIDTH-1:0] HEADING_RST =
        ANGLE_WIDTH'(((64'd19 << ANG_FRAC) + 64'd5) / 64'd10);
    localparam logic signed [LATLON_WIDTH-1:0] LAT_RST = LATLON_WIDTH'(deg_to_ll(64'd434507));
    localparam logic signed [LATLON_WIDTH-1:0] LON_RST = LATLON_WIDTH'(deg_to_ll(64'd399585));
    localparam logic signed [ALT_WIDTH-1:0]    ALT_RST = ALT_WIDTH'(1000 * 4096);
    localparam logic [GAIN_WIDTH-1:0]          GAIN_RST = GAIN_WIDTH'(6554);

    // rounding right shift, half away from zero
    function automatic logic signed [64:0] round_shr(input logic signed [64:0] v,
                                                     input int s);
        logic [64:0] mag;
        logic [64:0] r;
        mag = v[64] ? 65'(-v) : 65'(v);
        r   = (mag + (65'd1 << (s - 1))) >> s;
        return v[64] ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ----- rtl/flight_kinematics_integrator.sv -----
// ----------------------------------------------------------------------------
// flight_kinematics_integrator
// dead-reckoning integrator of attitude, speed and position, one tick per transfer
// ----------------------------------------------------------------------------
// One input transfer is one tick. Pitch, roll and speed follow their targets
// through a first-order lag, heading integrates its rate and wraps to +-pi,
// then latitude, longitude and altitude advance by time_step times the
// velocity. A tick takes longer while an earlier result still waits to be
// taken, and with each step of wrapping heading and of reducing pitch or
// latitude into +-pi. The time goes mostly into two 99-step restoring
// divisions by the earth radius (and by the radius times cos of latitude)
// and three 24-step cordic rotations, all on one shared multiplier, cordic
// stage and divider step. item_stall stays high for the whole tick. A
// finished result waits in its own output register, so the next tick may
// start while it is not taken.
// lag_gain and time_step sit at byte addresses 0 and 4 of the apb port.
module flight_kinematics_integrator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic signed [31:0]  pitch_target,
    input  logic signed [31:0]  roll_target,
    input  logic signed [31:0]  heading_rate,
    input  logic [23:0]         speed_target,
    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [31:0]  pitch,
    output logic signed [31:0]  roll,
    output logic signed [31:0]  heading,
    output logic [23:0]         speed,
    output logic signed [47:0]  latitude,
    output logic signed [47:0]  longitude,
    output logic signed [31:0]  altitude
);

    localparam int AW       = flki_pkg::ANGLE_WIDTH;
    localparam int LW       = flki_pkg::LATLON_WIDTH;
    localparam int SW       = flki_pkg::SPEED_WIDTH;
    localparam int HW       = flki_pkg::ALT_WIDTH;
    localparam int GW       = flki_pkg::GAIN_WIDTH;
    localparam int NUM_W    = 99;
    localparam int DEN_W    = 54;
    localparam int QUO_W    = 58;
    localparam int CNT_W    = $clog2(NUM_W);
    localparam int LAT_SCL  = 28;
    localparam int LON_SCL  = 58;

    typedef enum logic [16:0] {
        ST_IDLE     = 17'b00000000000000001,
        ST_LAG_MUL  = 17'b00000000000000010,
        ST_LAG_ADD  = 17'b00000000000000100,
        ST_HWRAP    = 17'b00000000000001000,
        ST_CRD_LOAD = 17'b00000000000010000,
        ST_CRD_RED  = 17'b00000000000100000,
        ST_CRD_ITER = 17'b00000000001000000,
        ST_CRD_DONE = 17'b00000000010000000,
        ST_VEL_MUL  = 17'b00000000100000000,
        ST_VEL_RND  = 17'b00000001000000000,
        ST_TS_MUL   = 17'b00000010000000000,
        ST_DEN_MUL  = 17'b00000100000000000,
        ST_DIV_INIT = 17'b00001000000000000,
        ST_DIV_ITER = 17'b00010000000000000,
        ST_DIV_DONE = 17'b00100000000000000,
        ST_ALT      = 17'b01000000000000000,
        ST_FINISH   = 17'b10000000000000000
    } state_t;

    typedef enum logic [1:0] {
        LANE_PITCH, LANE_ROLL, LANE_HEADING, LANE_SPEED
    } lane_t;

    typedef enum logic [1:0] {
        SRC_PITCH, SRC_HEADING, SRC_LAT
    } ang_src_t;

    typedef enum logic [1:0] {
        TGT_GAIN, TGT_LAT, TGT_LON, TGT_ALT
    } tgt_t;

    state_t   state_reg, state_next;
    lane_t    lane_reg;
    ang_src_t src_reg;
    tgt_t     tgt_reg;

    logic [GW-1:0] lag_gain_reg, time_step_reg;

    logic signed [AW-1:0] pitch_reg, roll_reg, heading_reg;
    logic [SW-1:0]        speed_reg;
    logic signed [LW-1:0] lat_reg, lon_reg;
    logic signed [HW-1:0] alt_reg;

    logic signed [AW-1:0] pt_reg, rt_reg, hr_reg;
    logic [SW-1:0]        st_reg;

    logic signed [AW-1:0] pitch_out_reg, roll_out_reg, heading_out_reg;
    logic [SW-1:0]        speed_out_reg;
    logic signed [LW-1:0] lat_out_reg, lon_out_reg;
    logic signed [HW-1:0] alt_out_reg;
    logic                 out_valid_reg;

    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [64:0] prod_reg;
    logic signed [64:0] rnd16, rnd20, rnd30;

    logic signed [33:0] hacc_reg;

    logic signed [63:0] ang_reg;
    logic               flip_reg;
    logic signed [33:0] cx_reg, cy_reg, crd_dx, crd_dy, cos_v, sin_v;
    logic signed [61:0] cz_reg, crd_atan;
    logic [flki_pkg::ITER_W-1:0] it_reg;

    logic signed [31:0] ct_reg, stt_reg, cp_reg, sp_reg;
    logic               cl_neg_reg;
    logic [30:0]        cmag_reg;
    logic [33:0]        cos_mag;

    logic signed [25:0] g_reg, vt_reg;
    logic signed [41:0] t_reg, t_src;
    logic [40:0]        t_mag;

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   rem_sh;
    logic             rem_ge;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;

    logic [42:0]          inc_mag;
    logic signed [43:0]   ll_inc;
    logic signed [LW-1:0] ll_base, ll_sat;
    logic signed [LW:0]   ll_sum;
    logic signed [HW:0]   alt_sum;
    logic signed [HW-1:0] alt_sat;

    logic item_acc, cfg_wr, out_load;

    assign pready     = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign cfg_wr     = psel && penable && pwrite;
    assign out_load   = (state_reg == ST_FINISH) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        case (paddr[2])
            flki_pkg::REG_LAG_GAIN:  prdata = {16'b0, lag_gain_reg};
            flki_pkg::REG_TIME_STEP: prdata = {16'b0, time_step_reg};
            default:                 prdata = '0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LAG_MUL:
            begin
                mul_b = $signed({16'b0, lag_gain_reg});
                case (lane_reg)
                    LANE_PITCH:   mul_a = 33'(pt_reg) - 33'(pitch_reg);
                    LANE_ROLL:    mul_a = 33'(rt_reg) - 33'(roll_reg);
                    LANE_HEADING: mul_a = 33'(hr_reg);
                    default:      mul_a = 33'($signed({1'b0, st_reg}))
                                          - 33'($signed({1'b0, speed_reg}));
                endcase
            end
            ST_VEL_MUL:
            begin
                case (tgt_reg)
                    TGT_GAIN:
                    begin
                        mul_a = 33'($signed({1'b0, speed_reg}));
                        mul_b = ct_reg;
                    end
                    TGT_LAT:
                    begin
                        mul_a = 33'(g_reg);
                        mul_b = cp_reg;
                    end
                    TGT_LON:
                    begin
                        mul_a = 33'(g_reg);
                        mul_b = sp_reg;
                    end
                    default:
                    begin
                        mul_a = 33'($signed({1'b0, speed_reg}));
                        mul_b = stt_reg;
                    end
                endcase
            end
            ST_TS_MUL:
            begin
                mul_a = 33'(vt_reg);
                mul_b = $signed({16'b0, time_step_reg});
            end
            ST_DEN_MUL:
            begin
                mul_a = 33'(flki_pkg::EARTH_RADIUS_M);
                mul_b = $signed({1'b0, cmag_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign rnd16 = flki_pkg::round_shr(prod_reg, 16);
    assign rnd20 = flki_pkg::round_shr(prod_reg, 20);
    assign rnd30 = flki_pkg::round_shr(prod_reg, 30);

    // cordic stage
    assign crd_dx   = cy_reg >>> it_reg;
    assign crd_dy   = cx_reg >>> it_reg;
    assign crd_atan = $signed(flki_pkg::ATAN_TBL[it_reg]);
    assign cos_v    = flip_reg ? -cx_reg : cx_reg;
    assign sin_v    = flip_reg ? -cy_reg : cy_reg;
    assign cos_mag  = cos_v[33] ? 34'(-cos_v) : 34'(cos_v);

    // divider step
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    assign t_src = (tgt_reg == TGT_LON) ? t_reg : $signed(prod_reg[41:0]);
    assign t_mag = t_src[41] ? 41'(-t_src) : 41'(t_src);

    assign inc_mag = 43'((59'(quo_reg) + (59'd1 << 15)) >> 16);
    assign ll_inc  = neg_reg ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
    assign ll_base = (tgt_reg == TGT_LON) ? lon_reg : lat_reg;
    assign ll_sum  = (LW+1)'(ll_base) + (LW+1)'(ll_inc);

    always_comb
    begin
        if (ll_sum > (LW+1)'($signed({1'b0, {(LW-1){1'b1}}}))) begin
            ll_sat = {1'b0, {(LW-1){1'b1}}};
        end else if (ll_sum < (LW+1)'($signed({1'b1, {(LW-1){1'b0}}}))) begin
            ll_sat = {1'b1, {(LW-1){1'b0}}};
        end else begin
            ll_sat = ll_sum[LW-1:0];
        end
    end

    assign alt_sum = (HW+1)'(alt_reg) + (HW+1)'($signed(rnd20[22:0]));

    always_comb
    begin
        if (alt_sum > (HW+1)'($signed({1'b0, {(HW-1){1'b1}}}))) begin
            alt_sat = {1'b0, {(HW-1){1'b1}}};
        end else if (alt_sum < (HW+1)'($signed({1'b1, {(HW-1){1'b0}}}))) begin
            alt_sat = {1'b1, {(HW-1){1'b0}}};
        end else begin
            alt_sat = alt_sum[HW-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc) begin
                    state_next = ST_LAG_MUL;
                end
            end
            ST_LAG_MUL:  state_next = ST_LAG_ADD;
            ST_LAG_ADD:
            begin
                case (lane_reg)
                    LANE_HEADING: state_next = ST_HWRAP;
                    LANE_SPEED:   state_next = ST_CRD_LOAD;
                    default:      state_next = ST_LAG_MUL;
                endcase
            end
            ST_HWRAP:
            begin
                if (hacc_reg < flki_pkg::PI_ANG && hacc_reg >= -flki_pkg::PI_ANG) begin
                    state_next = ST_LAG_MUL;
                end
            end
            ST_CRD_LOAD: state_next = ST_CRD_RED;
            ST_CRD_RED:
            begin
                if (ang_reg < flki_pkg::PI_Q58 && ang_reg >= -flki_pkg::PI_Q58) begin
                    state_next = ST_CRD_ITER;
                end
            end
            ST_CRD_ITER:
            begin
                if (it_reg == flki_pkg::ITER_W'(flki_pkg::CORDIC_ITERATIONS - 1)) begin
                    state_next = ST_CRD_DONE;
                end
            end
            ST_CRD_DONE:
            begin
                if (src_reg == SRC_PITCH) begin
                    state_next = ST_CRD_LOAD;
                end else begin
                    state_next = ST_VEL_MUL;
                end
            end
            ST_VEL_MUL:  state_next = ST_VEL_RND;
            ST_VEL_RND:
            begin
                if (tgt_reg == TGT_GAIN) begin
                    state_next = ST_VEL_MUL;
                end else begin
                    state_next = ST_TS_MUL;
                end
            end
            ST_TS_MUL:
            begin
                case (tgt_reg)
                    TGT_LAT: state_next = ST_DIV_INIT;
                    TGT_LON: state_next = ST_DEN_MUL;
                    default: state_next = ST_ALT;
                endcase
            end
            ST_DEN_MUL:  state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV_ITER;
            ST_DIV_ITER:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE:
            begin
                if (tgt_reg == TGT_LAT) begin
                    state_next = ST_CRD_LOAD;
                end else begin
                    state_next = ST_VEL_MUL;
                end
            end
            ST_ALT:      state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // control, configuration and kinematic state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            lane_reg      <= LANE_PITCH;
            src_reg       <= SRC_PITCH;
            tgt_reg       <= TGT_GAIN;
            lag_gain_reg  <= flki_pkg::GAIN_RST;
            time_step_reg <= flki_pkg::GAIN_RST;
            pitch_reg     <= '0;
            roll_reg      <= '0;
            heading_reg   <= flki_pkg::HEADING_RST;
            speed_reg     <= '0;
            lat_reg       <= flki_pkg::LAT_RST;
            lon_reg       <= flki_pkg::LON_RST;
            alt_reg       <= flki_pkg::ALT_RST;
            out_valid_reg <= 1'b0;
            it_reg        <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr) begin
                case (paddr[2])
                    flki_pkg::REG_LAG_GAIN:  lag_gain_reg  <= pwdata[GW-1:0];
                    flki_pkg::REG_TIME_STEP: time_step_reg <= pwdata[GW-1:0];
                    default:                 lag_gain_reg  <= lag_gain_reg;
                endcase
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (!result_stall) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    lane_reg <= LANE_PITCH;
                    src_reg  <= SRC_PITCH;
                    tgt_reg  <= TGT_GAIN;
                end
                ST_LAG_ADD:
                begin
                    case (lane_reg)
                        LANE_PITCH:
                        begin
                            pitch_reg <= pitch_reg + $signed(rnd16[AW-1:0]);
                            lane_reg  <= LANE_ROLL;
                        end
                        LANE_ROLL:
                        begin
                            roll_reg <= roll_reg + $signed(rnd16[AW-1:0]);
                            lane_reg <= LANE_HEADING;
                        end
                        LANE_HEADING: lane_reg <= LANE_HEADING;
                        default:      speed_reg <= speed_reg + rnd16[SW-1:0];
                    endcase
                end
                ST_HWRAP:
                begin
                    if (hacc_reg < flki_pkg::PI_ANG && hacc_reg >= -flki_pkg::PI_ANG) begin
                        heading_reg <= hacc_reg[AW-1:0];
                        lane_reg    <= LANE_SPEED;
                    end
                end
                ST_CRD_RED:  it_reg <= '0;
                ST_CRD_ITER: it_reg <= it_reg + 1'b1;
                ST_CRD_DONE:
                begin
                    case (src_reg)
                        SRC_PITCH:   src_reg <= SRC_HEADING;
                        SRC_HEADING: tgt_reg <= TGT_GAIN;
                        default:     tgt_reg <= TGT_LON;
                    endcase
                end
                ST_VEL_RND:
                begin
                    if (tgt_reg == TGT_GAIN) begin
                        tgt_reg <= TGT_LAT;
                    end
                end
                ST_DIV_INIT: cnt_reg <= '0;
                ST_DIV_ITER: cnt_reg <= cnt_reg + 1'b1;
                ST_DIV_DONE:
                begin
                    if (tgt_reg == TGT_LAT) begin
                        lat_reg <= ll_sat;
                        src_reg <= SRC_LAT;
                    end else begin
                        lon_reg <= ll_sat;
                        tgt_reg <= TGT_ALT;
                    end
                end
                ST_ALT:      alt_reg <= alt_sat;
                default:     lane_reg <= lane_reg;
            endcase
        end
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;

        if (item_acc) begin
            pt_reg <= pitch_target;
            rt_reg <= roll_target;
            hr_reg <= heading_rate;
            st_reg <= speed_target;
        end

        if (out_load) begin
            pitch_out_reg   <= pitch_reg;
            roll_out_reg    <= roll_reg;
            heading_out_reg <= heading_reg;
            speed_out_reg   <= speed_reg;
            lat_out_reg     <= lat_reg;
            lon_out_reg     <= lon_reg;
            alt_out_reg     <= alt_reg;
        end

        case (state_reg)
            ST_LAG_ADD:
            begin
                hacc_reg <= 34'(heading_reg) + $signed(rnd16[33:0]);
            end
            ST_HWRAP:
            begin
                if (hacc_reg >= flki_pkg::PI_ANG) begin
                    hacc_reg <= hacc_reg - flki_pkg::TWO_PI_ANG;
                end else if (hacc_reg < -flki_pkg::PI_ANG) begin
                    hacc_reg <= hacc_reg + flki_pkg::TWO_PI_ANG;
                end
            end
            ST_CRD_LOAD:
            begin
                case (src_reg)
                    SRC_PITCH:   ang_reg <= 64'($signed({pitch_reg, 30'b0}));
                    SRC_HEADING: ang_reg <= 64'($signed({heading_reg, 30'b0}));
                    default:     ang_reg <= 64'($signed({lat_reg, 14'b0}));
                endcase
            end
            ST_CRD_RED:
            begin
                cx_reg <= 34'($signed(flki_pkg::GAIN_Q30));
                cy_reg <= '0;
                if (ang_reg >= flki_pkg::PI_Q58) begin
                    ang_reg <= ang_reg - flki_pkg::TWO_PI_Q58;
                end else if (ang_reg < -flki_pkg::PI_Q58) begin
                    ang_reg <= ang_reg + flki_pkg::TWO_PI_Q58;
                end else if (ang_reg > flki_pkg::HALF_PI_Q58) begin
                    cz_reg   <= 62'(ang_reg - flki_pkg::PI_Q58);
                    flip_reg <= 1'b1;
                end else if (ang_reg < -flki_pkg::HALF_PI_Q58) begin
                    cz_reg   <= 62'(ang_reg + flki_pkg::PI_Q58);
                    flip_reg <= 1'b1;
                end else begin
                    cz_reg   <= 62'(ang_reg);
                    flip_reg <= 1'b0;
                end
            end
            ST_CRD_ITER:
            begin
                if (!cz_reg[61]) begin
                    cx_reg <= cx_reg - crd_dx;
                    cy_reg <= cy_reg + crd_dy;
                    cz_reg <= cz_reg - crd_atan;
                end else begin
                    cx_reg <= cx_reg + crd_dx;
                    cy_reg <= cy_reg - crd_dy;
                    cz_reg <= cz_reg + crd_atan;
                end
            end
            ST_CRD_DONE:
            begin
                case (src_reg)
                    SRC_PITCH:
                    begin
                        ct_reg  <= cos_v[31:0];
                        stt_reg <= sin_v[31:0];
                    end
                    SRC_HEADING:
                    begin
                        cp_reg <= cos_v[31:0];
                        sp_reg <= sin_v[31:0];
                    end
                    default:
                    begin
                        cl_neg_reg <= cos_v[33];
                        if (cos_mag < (34'd1 << 20)) begin
                            cmag_reg <= 31'd1 << 20;
                        end else begin
                            cmag_reg <= cos_mag[30:0];
                        end
                    end
                endcase
            end
            ST_VEL_RND:
            begin
                if (tgt_reg == TGT_GAIN) begin
                    g_reg <= rnd30[25:0];
                end else begin
                    vt_reg <= rnd30[25:0];
                end
            end
            ST_DEN_MUL:
            begin
                t_reg <= prod_reg[41:0];
            end
            ST_DIV_INIT:
            begin
                rem_reg <= '0;
                quo_reg <= '0;
                if (tgt_reg == TGT_LON) begin
                    den_reg <= prod_reg[DEN_W-1:0];
                    num_reg <= {t_mag, {LON_SCL{1'b0}}};
                    neg_reg <= t_src[41] ^ cl_neg_reg;
                end else begin
                    den_reg <= DEN_W'(flki_pkg::EARTH_RADIUS_M);
                    num_reg <= {{(NUM_W-41-LAT_SCL){1'b0}}, t_mag, {LAT_SCL{1'b0}}};
                    neg_reg <= t_src[41];
                end
            end
            ST_DIV_ITER:
            begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
                if (rem_ge) begin
                    rem_reg <= DEN_W'(rem_sh - {1'b0, den_reg});
                end else begin
                    rem_reg <= rem_sh[DEN_W-1:0];
                end
            end
            default:
            begin
                hacc_reg <= hacc_reg;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign pitch        = pitch_out_reg;
    assign roll         = roll_out_reg;
    assign heading      = heading_out_reg;
    assign speed        = speed_out_reg;
    assign latitude     = lat_out_reg;
    assign longitude    = lon_out_reg;
    assign altitude     = alt_out_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the flight kinematics integrator
// ----------------------------------------------------------------------------
// Every accepted tick is run through a fixed-point dead-reckoning model kept
// in a small scoreboard class. Each result transfer is checked field by field
// against the oldest predicted state. Gain and step are rewritten over the
// apb port between phases, while the block is idle, and in most phases both
// handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    typedef bit [63:0] u64_t;

    typedef struct packed {
        logic signed [31:0] pitch_target;
        logic signed [31:0] roll_target;
        logic signed [31:0] heading_rate;
        logic [23:0]        speed_target;
    } tick_t;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic signed [31:0] heading;
        logic [23:0]        speed;
        logic signed [47:0] latitude;
        logic signed [47:0] longitude;
        logic signed [31:0] altitude;
    } nav_state_t;

    localparam u64_t PI62 = 64'hC90FDAA22168C235;
    localparam longint RADIUS = 6400000;

    class nav_scoreboard;
        longint     atan_q58 [24];
        longint     pi58;
        longint     gain_k30;
        bit [15:0]  lag_gain;
        bit [15:0]  time_step;
        longint     pitch_now, roll_now, head_now, speed_now, lat_now, lon_now, alt_now;
        nav_state_t pending [$];
        int         errors;

        function u64_t mag(longint v);
            return v < 0 ? u64_t'(-v) : u64_t'(v);
        endfunction

        function longint rnd_shr(longint v, int s);
            u64_t r;
            r = (mag(v) + (u64_t'(1) << (s - 1))) >> s;
            return v < 0 ? -longint'(r) : longint'(r);
        endfunction

        function longint lag_mul(longint v, u64_t g);
            u64_t m, r;
            m = mag(v);
            r = (m >> 16) * g + (((m & 64'hFFFF) * g + 64'h8000) >> 16);
            return v < 0 ? -longint'(r) : longint'(r);
        endfunction

        function longint sat_add(longint a, longint b, int w);
            longint mx, mn;
            mx = longint'((u64_t'(1) << (w - 1)) - 1);
            mn = -mx - 1;
            if (b > 0 && a > mx - b) return mx;
            if (b < 0 && a < mn - b) return mn;
            return a + b;
        endfunction

        function u64_t long_div(u64_t n, u64_t d, int k);
            u64_t q, r;
            if (d == 0) return 0;
            q = n / d;
            r = n % d;
            for (int i = 0; i < k; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        function longint to_latlon(u64_t q60);
            return longint'((q60 + (u64_t'(1) << 15)) >> 16);
        endfunction

        function longint pos_incr(longint num, u64_t den, int k, bit neg);
            longint r;
            r = to_latlon(long_div(mag(num), den, k));
            if (num < 0) neg = !neg;
            return neg ? -r : r;
        endfunction

        function u64_t int_sqrt(u64_t n);
            u64_t res, b;
            res = 0;
            b = u64_t'(1) << 62;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function void rotate(longint a, output longint c, output longint s);
            longint x, y, z, dx, dy, half;
            bit     flip;
            x = gain_k30;
            y = 0;
            half = pi58 / 2;
            flip = 0;
            while (a >= pi58) a -= 2 * pi58;
            while (a < -pi58) a += 2 * pi58;
            if (a > half)
            begin
                a -= pi58;
                flip = 1;
            end
            else if (a < -half)
            begin
                a += pi58;
                flip = 1;
            end
            z = a;
            for (int i = 0; i < 24; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= atan_q58[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += atan_q58[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function new();
            longint sum, term;
            int     e;
            u64_t   p, sq;
            pi58 = longint'((PI62 + 8) >> 4);
            atan_q58[0] = longint'(((PI62 >> 2) + 8) >> 4);
            for (int i = 1; i < 24; i++)
            begin
                sum = 0;
                for (int k = 0; k < 64; k++)
                begin
                    e = 62 - i * (2 * k + 1);
                    if (e >= 0)
                    begin
                        term = longint'((u64_t'(1) << e) / u64_t'(2 * k + 1));
                        sum = (k & 1) ? sum - term : sum + term;
                    end
                end
                atan_q58[i] = (sum + 8) >>> 4;
            end
            p = u64_t'(1) << 30;
            for (int i = 0; i < 24; i++)
                p = p + (p >> (2 * i));
            sq = int_sqrt(p << 30);
            gain_k30 = longint'(((u64_t'(1) << 60) + sq / 2) / sq);
            lag_gain = 6554;
            time_step = 6554;
            pitch_now = 0;
            roll_now = 0;
            speed_now = 0;
            head_now = longint'(((u64_t'(19) << 28) + 5) / 10);
            lat_now = to_latlon(long_div((PI62 >> 22) * 434507, 1800000, 20));
            lon_now = to_latlon(long_div((PI62 >> 22) * 399585, 1800000, 20));
            alt_now = 1000 * 4096;
            errors = 0;
        endfunction

        function void set_reg(logic idx, bit [15:0] value);
            if (idx == flki_pkg::REG_LAG_GAIN) lag_gain = value;
            else time_step = value;
        endfunction

        function void note_tick(tick_t t);
            longint     h, pi_a, ct, st, cp, sp, cl, sl, g, d, lat58;
            u64_t       cmag;
            nav_state_t e;
            pitch_now += lag_mul(longint'(t.pitch_target) - pitch_now, lag_gain);
            roll_now += lag_mul(longint'(t.roll_target) - roll_now, lag_gain);
            pi_a = longint'((PI62 + (u64_t'(1) << 33)) >> 34);
            h = head_now + lag_mul(longint'(t.heading_rate), lag_gain);
            while (h >= pi_a) h -= 2 * pi_a;
            while (h < -pi_a) h += 2 * pi_a;
            head_now = h;
            speed_now += lag_mul(longint'({40'd0, t.speed_target}) - speed_now, lag_gain);
            rotate(pitch_now * (longint'(1) << 30), ct, st);
            rotate(head_now * (longint'(1) << 30), cp, sp);
            g = rnd_shr(speed_now * ct, 30);
            d = rnd_shr(g * cp, 30) * longint'(time_step);
            lat_now = sat_add(lat_now, pos_incr(d, RADIUS, 28, 0), 48);
            lat58 = lat_now * (longint'(1) << 14);
            rotate(lat58, cl, sl);
            cmag = mag(cl);
            if (cmag < (u64_t'(1) << 20)) cmag = u64_t'(1) << 20;
            d = rnd_shr(g * sp, 30) * longint'(time_step);
            lon_now = sat_add(lon_now, pos_incr(d, u64_t'(RADIUS) * cmag, 58, cl < 0), 48);
            d = rnd_shr(speed_now * st, 30) * longint'(time_step);
            alt_now = sat_add(alt_now, rnd_shr(d, 20), 32);
            e.pitch = pitch_now[31:0];
            e.roll = roll_now[31:0];
            e.heading = head_now[31:0];
            e.speed = speed_now[23:0];
            e.latitude = lat_now[47:0];
            e.longitude = lon_now[47:0];
            e.altitude = alt_now[31:0];
            pending.push_back(e);
        endfunction

        function void check_result(nav_state_t a);
            nav_state_t e;
            if (pending.size() == 0)
            begin
                $error("result transfer with no tick pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.pitch !== e.pitch)
            begin
                $error("pitch: expected %0d, got %0d", e.pitch, a.pitch);
                errors++;
            end
            if (a.roll !== e.roll)
            begin
                $error("roll: expected %0d, got %0d", e.roll, a.roll);
                errors++;
            end
            if (a.heading !== e.heading)
            begin
                $error("heading: expected %0d, got %0d", e.heading, a.heading);
                errors++;
            end
            if (a.speed !== e.speed)
            begin
                $error("speed: expected %0d, got %0d", e.speed, a.speed);
                errors++;
            end
            if (a.latitude !== e.latitude)
            begin
                $error("latitude: expected %0d, got %0d", e.latitude, a.latitude);
                errors++;
            end
            if (a.longitude !== e.longitude)
            begin
                $error("longitude: expected %0d, got %0d", e.longitude, a.longitude);
                errors++;
            end
            if (a.altitude !== e.altitude)
            begin
                $error("altitude: expected %0d, got %0d", e.altitude, a.altitude);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic signed [31:0] pitch_target = '0;
    logic signed [31:0] roll_target = '0;
    logic signed [31:0] heading_rate = '0;
    logic [23:0]        speed_target = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [31:0] pitch;
    logic signed [31:0] roll;
    logic signed [31:0] heading;
    logic [23:0]        speed;
    logic signed [47:0] latitude;
    logic signed [47:0] longitude;
    logic signed [31:0] altitude;

    nav_scoreboard sb = new();
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    flight_kinematics_integrator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .pitch_target (pitch_target),
        .roll_target  (roll_target),
        .heading_rate (heading_rate),
        .speed_target (speed_target),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pitch        (pitch),
        .roll         (roll),
        .heading      (heading),
        .speed        (speed),
        .latitude     (latitude),
        .longitude    (longitude),
        .altitude     (altitude)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result({pitch, roll, heading, speed, latitude, longitude, altitude});
    end

    task automatic write_reg(logic idx, bit [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom_range(65535)), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic send_tick(tick_t t);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        item_valid <= 1'b1;
        pitch_target <= t.pitch_target;
        roll_target <= t.roll_target;
        heading_rate <= t.heading_rate;
        speed_target <= t.speed_target;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_tick(t);
    endtask

    function automatic tick_t random_tick();
        tick_t t;
        t.pitch_target = $urandom();
        t.roll_target = $urandom();
        t.heading_rate = $urandom();
        t.speed_target = 24'($urandom());
        if ($urandom_range(99) < 75)
        begin
            t.pitch_target = int'($urandom_range(322122546)) - 161061273;
            t.roll_target = int'($urandom_range(536870912)) - 268435456;
            t.heading_rate = int'($urandom_range(268435456)) - 134217728;
        end
        return t;
    endfunction

    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        tick_t     t;
        bit [15:0] gains [7];
        bit [15:0] steps [7];
        gains = '{6554, 65535, 1, 0, 6554, 40000, 32768};
        steps = '{6554, 65535, 1, 0, 65535, 20000, 1000};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(flki_pkg::REG_LAG_GAIN, 16'd6554);
        write_reg(flki_pkg::REG_TIME_STEP, 16'd6554);
        // corners of every field, then pitch pushed beyond pi
        send_tick('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF});
        send_tick('{32'sh80000000, 32'sh80000000, 32'sh80000000, 24'h000000});
        send_tick('{32'sh00000000, 32'sh00000000, 32'sh00000000, 24'hFFFFFF});
        send_tick('{32'shFFFFFFFF, 32'sh00000001, 32'sh80000000, 24'h800000});
        send_tick('{32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 24'h555555});
        send_tick('{32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 24'hAAAAAA});
        repeat (10) send_tick('{32'sh7FFFFFFF, 32'sh10000000, 32'sh04000000, 24'hFFFFFF});
        repeat (4) send_tick('{32'sh80000000, 32'shF0000000, 32'shFC000000, 24'hFFFFFF});
        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            write_reg(flki_pkg::REG_LAG_GAIN,
                      ph >= 5 ? 16'($urandom_range(65535, 1)) : gains[ph]);
            write_reg(flki_pkg::REG_TIME_STEP,
                      ph >= 5 ? 16'($urandom_range(65535, 1)) : steps[ph]);
            send_idle_pct = (ph % 3 == 0) ? 24 : (ph % 3 == 1) ? 46 : 0;
            recv_idle_pct = (ph % 3 == 0) ? 46 : (ph % 3 == 1) ? 24 : 0;
            for (int n = 0; n < 97; n++)
            begin
                t = random_tick();
                send_tick(t);
            end
        end
        item_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
